[src/k_way_merge_engine_core_defines.svh]
// Assertion shorthands for the merge engine checker.
`ifndef K_WAY_MERGE_ENGINE_CORE_DEFINES_SVH
`define K_WAY_MERGE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, reset-qualified
`define KWME_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset-qualified
`define KWME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/kwme_pkg.sv]
package kwme_pkg;

	localparam int NUM_LISTS_DEF  = 8;
	localparam int LIST_DEPTH_DEF = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [3:0] ACTIVE_RST = 4'd8;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_TAKE  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_REJ   = 2'd1;
	localparam logic [1:0] STAT_TAKEN = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOAD   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

[src/kwme_ram.sv]
module kwme_ram #(
	parameter int WIDTH = kwme_pkg::DATA_WIDTH_DEF,
	parameter int DEPTH = kwme_pkg::NUM_LISTS_DEF * kwme_pkg::LIST_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/k_way_merge_engine_core.sv]
// K-way merge engine: NUM_LISTS stacks of LIST_DEPTH signed entries each.
// Command channel: start/busy. A beat is taken at a clock edge with start
// high and busy low; kind selects load (push value onto list_sel), take
// (pop the smallest head among the active lists, lowest list wins ties) or
// clear (empty every list).
// Result channel: done is high for one cycle with status, out_value and
// out_list; the receiver cannot stall it, so results are never held.
// Clear and unknown kinds raise done in the cycle after accept; load passes
// through ST_LOAD, take through ST_SCAN and then ST_FINISH. One
// comparator walks the list heads one per cycle, the head read through the
// single read port of the list memory; only one command is in flight.
// Config: cfg_we/cfg_wdata write active_lists at any edge; write only while idle.
// Reset (arst_n low): all fill counts zero, active_lists 8, no result
// pending. The list memory itself is not cleared; fill counts guard it.
module k_way_merge_engine_core #(
	parameter int NUM_LISTS  = kwme_pkg::NUM_LISTS_DEF,
	parameter int LIST_DEPTH = kwme_pkg::LIST_DEPTH_DEF,
	parameter int DATA_WIDTH = kwme_pkg::DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [2:0]         list_sel,
	input  logic signed [31:0] value,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] out_value,
	output logic [2:0]         out_list
);

	localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int NW = ($clog2(NUM_LISTS + 1) > 4) ? $clog2(NUM_LISTS + 1) : 4;
	localparam int FW = $clog2(LIST_DEPTH + 1);
	localparam int MD = NUM_LISTS * LIST_DEPTH;
	localparam int AW = $clog2(MD);
	localparam int XW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

	kwme_pkg::state_t state_q;

	logic [3:0]            act_q;
	logic [NW-1:0]         act_n;
	logic [FW-1:0]         fill_q [NUM_LISTS];
	logic [NW-1:0]         cur_q;
	logic [FW-1:0]         fill_cur;
	logic                  rej_q;
	logic [DATA_WIDTH-1:0] value_q;

	logic                  vld_s1;
	logic [LW-1:0]         idx_s1;
	logic [FW-1:0]         fill_s1;

	logic                  found_q;
	logic [DATA_WIDTH-1:0] best_val_q;
	logic [LW-1:0]         best_idx_q;
	logic [FW-1:0]         best_fill_q;

	logic                  done_q;
	logic [1:0]            status_q;
	logic [31:0]           out_value_q;
	logic [2:0]            out_list_q;

	logic [AW-1:0]         base_addr;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic                  ram_we;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  scan_issue;
	logic                  take_better;
	logic [XW-1:0]         val_ext;
	logic [XW-1:0]         best_ext;

	assign act_n = (NW'(act_q) > NW'(NUM_LISTS)) ? NW'(NUM_LISTS) : NW'(act_q);
	assign fill_cur = fill_q[cur_q[LW-1:0]];

	assign base_addr = AW'(cur_q[LW-1:0]) * AW'(LIST_DEPTH);
	assign wr_addr   = base_addr + AW'(fill_cur);
	assign rd_addr   = base_addr + AW'(fill_cur) - AW'(1);

	assign ram_we = (state_q == kwme_pkg::ST_LOAD) && !rej_q &&
			(fill_cur != FW'(LIST_DEPTH));
	assign scan_issue = (state_q == kwme_pkg::ST_SCAN) && (cur_q < act_n);
	// single shared comparator; strict less keeps the lowest list on ties
	assign take_better = vld_s1 &&
			(!found_q || ($signed(rd_data) < $signed(best_val_q)));

	assign val_ext  = XW'(value);
	assign best_ext = XW'($signed(best_val_q));

	kwme_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(MD)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata(value_q),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kwme_pkg::ST_IDLE;
			act_q   <= kwme_pkg::ACTIVE_RST;
			cur_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				act_q <= cfg_wdata;
			end
			done_q <= 1'b0;
			vld_s1 <= scan_issue && (fill_cur != '0);
			if (take_better) begin
				found_q <= 1'b1;
			end
			case (state_q)
				kwme_pkg::ST_IDLE: begin
					if (start) begin
						case (kind)
							kwme_pkg::KIND_LOAD: begin
								cur_q   <= NW'(list_sel);
								state_q <= kwme_pkg::ST_LOAD;
							end
							kwme_pkg::KIND_TAKE: begin
								cur_q   <= '0;
								found_q <= 1'b0;
								state_q <= kwme_pkg::ST_SCAN;
							end
							kwme_pkg::KIND_CLEAR: begin
								for (int i = 0; i < NUM_LISTS; i++) begin
									fill_q[i] <= '0;
								end
								done_q <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				kwme_pkg::ST_LOAD: begin
					if (ram_we) begin
						fill_q[cur_q[LW-1:0]] <= fill_cur + FW'(1);
					end
					done_q  <= 1'b1;
					state_q <= kwme_pkg::ST_IDLE;
				end
				kwme_pkg::ST_SCAN: begin
					// last head's compare lands in the cycle the walk ends
					if (scan_issue) begin
						cur_q <= cur_q + NW'(1);
					end else begin
						state_q <= kwme_pkg::ST_FINISH;
					end
				end
				kwme_pkg::ST_FINISH: begin
					if (found_q) begin
						fill_q[best_idx_q] <= best_fill_q - FW'(1);
					end
					done_q  <= 1'b1;
					state_q <= kwme_pkg::ST_IDLE;
				end
				default: begin
					state_q <= kwme_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cur_q[LW-1:0];
		fill_s1 <= fill_cur;
		if (take_better) begin
			best_val_q  <= rd_data;
			best_idx_q  <= idx_s1;
			best_fill_q <= fill_s1;
		end
		case (state_q)
			kwme_pkg::ST_IDLE: begin
				if (start) begin
					rej_q       <= (NW'(list_sel) >= act_n);
					value_q     <= val_ext[DATA_WIDTH-1:0];
					status_q    <= (kind == kwme_pkg::KIND_CLEAR) ?
							kwme_pkg::STAT_OK : kwme_pkg::STAT_REJ;
					out_value_q <= '0;
					out_list_q  <= '0;
				end
			end
			kwme_pkg::ST_LOAD: begin
				status_q    <= ram_we ? kwme_pkg::STAT_OK : kwme_pkg::STAT_REJ;
				out_value_q <= '0;
				out_list_q  <= '0;
			end
			kwme_pkg::ST_FINISH: begin
				if (found_q) begin
					status_q    <= kwme_pkg::STAT_TAKEN;
					out_value_q <= best_ext[31:0];
					out_list_q  <= 3'(best_idx_q);
				end else begin
					status_q    <= kwme_pkg::STAT_EMPTY;
					out_value_q <= '0;
					out_list_q  <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != kwme_pkg::ST_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign out_value = out_value_q;
	assign out_list  = out_list_q;

endmodule

[src/kwme_checker.sv]
`include "k_way_merge_engine_core_defines.svh"

module kwme_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         kind,
	input logic               done,
	input logic [1:0]         status,
	input logic signed [31:0] out_value,
	input logic [2:0]         out_list
);

	logic acc;
	assign acc = start && !busy;

	// load and take leave the engine busy after the accepting edge
	`KWME_ASSERT_NEXT(a_multi_busy, acc && (kind == kwme_pkg::KIND_LOAD || kind == kwme_pkg::KIND_TAKE), busy, "load/take did not raise busy")

	// clear answers on the next cycle with OK
	`KWME_ASSERT_NEXT(a_clear_done, acc && kind == kwme_pkg::KIND_CLEAR, done && status == kwme_pkg::STAT_OK, "clear beat missing")

	// a load beat has no result the cycle right after accept
	`KWME_ASSERT_NEXT(a_load_lat, acc && kind == kwme_pkg::KIND_LOAD, !done, "load result too early")

	// only a taken value carries payload
	`KWME_ASSERT_NOW(a_zero_pay, done && status != kwme_pkg::STAT_TAKEN, out_value == 32'sd0 && out_list == 3'd0, "payload not zero")

endmodule

bind k_way_merge_engine_core kwme_checker u_kwme_checker (.*);

[bench/k_way_merge_engine_core_tb.sv]
`timescale 1ns / 100ps

module k_way_merge_engine_core_tb;
	import kwme_pkg::*;

	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] val;
		logic [2:0]         list;
	} merge_reply_t;

	class merge_scoreboard;
		logic signed [31:0] stack_mem [NUM_LISTS_DEF][LIST_DEPTH_DEF];
		int                 fill [NUM_LISTS_DEF];
		logic [3:0]         active;
		merge_reply_t       reply_q [$];
		int                 errors;

		function new();
			active = ACTIVE_RST;
			errors = 0;
			foreach (fill[i])
				fill[i] = 0;
		endfunction

		function void set_active(logic [3:0] cnt);
			active = cnt;
		endfunction

		// next reply of the merge engine, state updated as the block would
		function merge_reply_t merge_predict(logic [1:0] k, logic [2:0] sel,
			logic signed [31:0] v);
			merge_reply_t       r;
			int                 n;
			int                 best;
			bit                 found;
			logic signed [31:0] head;
			logic signed [31:0] best_val;
			r = '{status: STAT_REJ, val: '0, list: '0};
			n = (active > NUM_LISTS_DEF) ? NUM_LISTS_DEF : int'(active);
			found = 1'b0;
			best = 0;
			best_val = '0;
			case (k)
				KIND_LOAD: begin
					if (int'(sel) < n && fill[sel] < LIST_DEPTH_DEF) begin
						stack_mem[sel][fill[sel]] = v;
						fill[sel]++;
						r.status = STAT_OK;
					end
				end
				KIND_TAKE: begin
					for (int l = 0; l < n; l++) begin
						if (fill[l] != 0) begin
							head = stack_mem[l][fill[l] - 1];
							// strict less keeps the lowest list on ties
							if (!found || head < best_val) begin
								found = 1'b1;
								best = l;
								best_val = head;
							end
						end
					end
					if (!found) begin
						r.status = STAT_EMPTY;
					end else begin
						fill[best]--;
						r.status = STAT_TAKEN;
						r.val = best_val;
						r.list = best[2:0];
					end
				end
				KIND_CLEAR: begin
					foreach (fill[i])
						fill[i] = 0;
					r.status = STAT_OK;
				end
				default: r.status = STAT_REJ;
			endcase
			return r;
		endfunction

		function void note_command(logic [1:0] k, logic [2:0] sel, logic signed [31:0] v);
			reply_q.push_back(merge_predict(k, sel, v));
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [1:0] st, logic signed [31:0] val, logic [2:0] list);
			merge_reply_t want;
			if (reply_q.size() == 0) begin
				report_mismatch($sformatf("unexpected beat status %0d value %0d list %0d",
					st, val, list));
			end else begin
				want = reply_q.pop_front();
				if (st !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", st, want.status));
				if (val !== want.val)
					report_mismatch($sformatf("out_value %0d, want %0d", val, want.val));
				if (list !== want.list)
					report_mismatch($sformatf("out_list %0d, want %0d", list, want.list));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         kind;
	logic [2:0]         list_sel;
	logic signed [31:0] value;
	logic               cfg_we;
	logic [3:0]         cfg_wdata;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] out_value;
	logic [2:0]         out_list;

	merge_scoreboard sb = new();
	int cycles = 0;

	k_way_merge_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.list_sel  (list_sel),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.status    (status),
		.out_value (out_value),
		.out_list  (out_list)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(status, out_value, out_list);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// called just after a rising edge; returns at the edge that takes the beat
	task automatic send_cmd(logic [1:0] k, logic [2:0] sel, logic signed [31:0] v);
		start <= 1'b1;
		kind <= k;
		list_sel <= sel;
		value <= v;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_command(k, sel, v);
	endtask

	task automatic idle_gap(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.reply_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_active(logic [3:0] cnt);
		drain();
		while (busy !== 1'b0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cnt;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_active(cnt);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(4))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return -32'sd1;
					3: return 32'sd1;
					default: return 32'sd0;
				endcase
			end
			// narrow range makes ties between heads common
			1: return $signed(32'($urandom_range(6))) - 32'sd3;
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic run_phase(logic [3:0] cnt, int idle_pct, int w_load, int w_take,
		int w_clear, int count);
		int                 n;
		int                 r;
		logic [1:0]         k;
		logic [2:0]         sel;
		logic signed [31:0] v;
		write_active(cnt);
		n = (cnt > NUM_LISTS_DEF) ? NUM_LISTS_DEF : int'(cnt);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < w_load)
				k = KIND_LOAD;
			else if (r < w_load + w_take)
				k = KIND_TAKE;
			else if (r < w_load + w_take + w_clear)
				k = KIND_CLEAR;
			else
				k = KIND_UNKNOWN;
			if (n > 0 && $urandom_range(99) < 85)
				sel = 3'($urandom_range(n - 1, 0));
			else
				sel = 3'($urandom);
			v = pick_value();
			send_cmd(k, sel, v);
			if (i == count / 2)
				drain();
			else if ($urandom_range(99) < idle_pct)
				idle_gap($urandom_range(14, 1));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_LOAD;
		list_sel = '0;
		value = '0;
		cfg_we = 1'b0;
		cfg_wdata = ACTIVE_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty take, extremes, ties, unknown kind, clear
		send_cmd(KIND_TAKE, 3'd0, 32'sd0);
		send_cmd(KIND_LOAD, 3'd0, 32'sh7fff_ffff);
		send_cmd(KIND_LOAD, 3'd7, 32'sh8000_0000);
		send_cmd(KIND_LOAD, 3'd3, 32'sd0);
		send_cmd(KIND_LOAD, 3'd3, -32'sd1);
		send_cmd(KIND_LOAD, 3'd5, -32'sd1);
		repeat (6) send_cmd(KIND_TAKE, 3'd7, 32'sd0);
		send_cmd(KIND_UNKNOWN, 3'd7, 32'sh7fff_ffff);
		send_cmd(KIND_LOAD, 3'd2, 32'sd5);
		send_cmd(KIND_CLEAR, 3'd0, 32'sd0);
		send_cmd(KIND_TAKE, 3'd0, 32'sd0);
		// lowered active count hides list 6 until restored
		send_cmd(KIND_LOAD, 3'd0, 32'sd42);
		send_cmd(KIND_LOAD, 3'd6, -32'sd7);
		write_active(4'd2);
		send_cmd(KIND_LOAD, 3'd6, 32'sd1);
		send_cmd(KIND_TAKE, 3'd0, 32'sd0);
		send_cmd(KIND_TAKE, 3'd0, 32'sd0);
		write_active(4'd0);
		send_cmd(KIND_LOAD, 3'd0, 32'sd3);
		send_cmd(KIND_TAKE, 3'd0, 32'sd0);
		write_active(4'd8);
		send_cmd(KIND_TAKE, 3'd0, 32'sd0);

		run_phase(4'd8, 0, 55, 40, 2, 100);
		// one list, load heavy: drives list 0 to full
		run_phase(4'd1, 56, 85, 10, 0, 110);
		run_phase(4'd3, 0, 50, 45, 2, 90);
		run_phase(4'd8, 21, 60, 35, 2, 90);
		run_phase(4'd15, 56, 50, 45, 2, 60);
		run_phase(4'd5, 21, 45, 50, 2, 80);
		run_phase(4'd0, 0, 50, 45, 2, 10);
		run_phase(4'd8, 0, 30, 65, 2, 60);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.reply_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

[k_way_merge_engine_core.f]
+incdir+src
src/kwme_pkg.sv
src/kwme_ram.sv
src/k_way_merge_engine_core.sv
src/kwme_checker.sv
bench/k_way_merge_engine_core_tb.sv
